/* src/prefilled_moving_average_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the prefilled moving average block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PREFILLED_MOVING_AVERAGE_ASSERT_SVH
`define PREFILLED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication
`define PMA_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pma assertion failed");

// Next-cycle implication
`define PMA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pma assertion failed");

`endif

/* src/pma_pkg.sv */
// ----------------------------------------------------------------------------
// pma_pkg
// Shared widths, constants and types of the prefilled moving average block.
// ----------------------------------------------------------------------------
package pma_pkg;

    localparam int DATA_W         = 16;
    localparam int LEN_REG_W      = 5;
    localparam int LEN_RESET      = 4;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } pma_div_status_t;

endpackage

/* src/pma_if.sv */
// ----------------------------------------------------------------------------
// pma_if
// Valid/ready stream interfaces for the sample and average channels.
// ----------------------------------------------------------------------------
interface pma_sample_if
    import pma_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pma_average_if
    import pma_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

/* src/pma_window_ram.sv */
// ----------------------------------------------------------------------------
// pma_window_ram
// Sample ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pma_window_ram
    import pma_pkg::*;
#(
    parameter int DEPTH = MAX_WINDOW_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pma_divider.sv */
// ----------------------------------------------------------------------------
// pma_divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module pma_divider
    import pma_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int LEN_W = 5
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output pma_div_status_t  status
);

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* src/prefilled_moving_average.sv */
// Flow: a sample transfer passes through ST_UPDATE for a primed window, or through
//   ST_FILL once per window entry for the prefilling sample, then ST_DIV and ST_DIV_WAIT.
// A new sample is taken only in ST_IDLE, once the previous average is registered; the
//   bit-serial divider runs one quotient bit per cycle over the 20-bit sum.
// Reset: rst_n clears the sum, pointer and primed flag; window length returns to 4.
// ----------------------------------------------------------------------------
// prefilled_moving_average
// Boxcar average over a configurable window, prefilled by its first sample.
// ----------------------------------------------------------------------------
`include "prefilled_moving_average_assert.svh"

module prefilled_moving_average
    import pma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    pma_sample_if.sink            sample_ch,
    pma_average_if.source         average_ch
);

    localparam int LEN_MAX = (1 << LEN_REG_W) - 1;
    localparam int EFF_MAX = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
    localparam int LEN_W   = $clog2(EFF_MAX + 1);
    localparam int PTR_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int SUM_W   = DATA_W + $clog2(EFF_MAX);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPDATE   = 3'd1;
    localparam logic [2:0] ST_FILL     = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [LEN_REG_W-1:0] wlen_reg, wlen_next;
    logic                 primed_reg, primed_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [PTR_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    sample_reg, sample_next;
    logic [DATA_W-1:0]    average_reg, average_next;

    logic [LEN_W-1:0]     eff_len;
    logic                 cfg_write;
    logic                 in_fire;
    logic                 out_fire;
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 div_start;
    logic [SUM_W-1:0]     div_quotient;
    pma_div_status_t      div_status;

    // Clamp the register to 1..EFF_MAX
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (wlen_reg > LEN_REG_W'(EFF_MAX))
        begin
            eff_len = LEN_W'(EFF_MAX);
        end
        else
        begin
            eff_len = LEN_W'(wlen_reg);
        end
    end

    assign pready    = 1'b1;
    assign prdata    = APB_DATA_W'(wlen_reg);
    assign cfg_write = psel && penable && pwrite;

    assign sample_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire          = sample_ch.valid && sample_ch.ready;
    assign average_ch.valid = out_valid_reg;
    assign average_ch.average = average_reg;
    assign out_fire         = out_valid_reg && average_ch.ready;

    assign ram_we    = (state_reg == ST_UPDATE) || (state_reg == ST_FILL);
    assign ram_waddr = (state_reg == ST_FILL) ? cnt_reg : ptr_reg;
    assign div_start = (state_reg == ST_DIV);

    always_comb
    begin
        state_next     = state_reg;
        wlen_next      = wlen_reg;
        primed_next    = primed_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        average_next   = average_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            wlen_next   = pwdata[LEN_REG_W-1:0];
            primed_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = sample_ch.sample;
                    if (primed_reg)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = ST_FILL;
                    end
                end
            end
            ST_UPDATE:
            begin
                // Drop the oldest entry, append the new one
                sum_next = sum_reg - SUM_W'(ram_rdata) + SUM_W'(sample_reg);
                if (LEN_W'(ptr_reg) + LEN_W'(1) == eff_len)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                state_next = ST_DIV;
            end
            ST_FILL:
            begin
                sum_next = sum_reg + SUM_W'(sample_reg);
                cnt_next = cnt_reg + PTR_W'(1);
                if (LEN_W'(cnt_reg) + LEN_W'(1) == eff_len)
                begin
                    primed_next = 1'b1;
                    ptr_next    = (eff_len == LEN_W'(1)) ? PTR_W'(0) : PTR_W'(1);
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                // Hold the quotient until the output slot is free
                if (div_status.done && (!out_valid_reg || average_ch.ready))
                begin
                    average_next   = div_quotient[DATA_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= LEN_REG_W'(LEN_RESET);
            primed_reg    <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            primed_reg    <= primed_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        average_reg <= average_next;
    end

    pma_window_ram #(
        .DEPTH (EFF_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    pma_divider #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (eff_len),
        .quotient (div_quotient),
        .status   (div_status)
    );

    `PMA_ASSERT_SAME(a_ready_not_dividing, sample_ch.ready, !div_status.busy)
    `PMA_ASSERT_NEXT(a_primed_goes_update, in_fire && primed_reg, state_reg == ST_UPDATE)
    `PMA_ASSERT_SAME(a_fill_unprimed, state_reg == ST_FILL, !primed_reg)
    `PMA_ASSERT_SAME(a_ptr_in_window, primed_reg, LEN_W'(ptr_reg) < eff_len)

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Moving average testbench
// Drives samples and window-length writes into prefilled_moving_average and
// checks every average against its typed value in the step table or against an
// in-bench model of the boxcar window. The run starts with a table of directed
// steps, then random phases that each begin with a length write. Both stream
// sides idle at random, and the average side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import pma_pkg::*;

    localparam int PERIOD       = 20;
    localparam int MAX_WIN      = MAX_WINDOW_DEF;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_STEPS    = 25;

    localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = '0;

    typedef struct packed {
        logic              set_len;
        logic [4:0]        len;
        logic [DATA_W-1:0] sample;
        logic              typed;
        logic [DATA_W-1:0] average;
    } step_t;

    // Typed averages follow from the prefill rule and the window length.
    step_t directed_steps [NUM_STEPS] = '{
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b0, 5'd0,  16'h0000, 1'b1, 16'hBFFF},
        '{1'b0, 5'd0,  16'h0000, 1'b0, 16'h0000},
        '{1'b1, 5'd0,  16'h1234, 1'b1, 16'h1234},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b0, 5'd0,  16'h0000, 1'b1, 16'h0000},
        '{1'b1, 5'd31, 16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b0, 5'd0,  16'h0000, 1'b1, 16'hEFFF},
        '{1'b0, 5'd0,  16'h0000, 1'b0, 16'h0000},
        '{1'b1, 5'd16, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, 16'h0FFF},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, 16'h0000},
        '{1'b1, 5'd1,  16'hAAAA, 1'b1, 16'hAAAA},
        '{1'b0, 5'd0,  16'h5555, 1'b1, 16'h5555},
        '{1'b1, 5'd17, 16'h8000, 1'b1, 16'h8000},
        '{1'b0, 5'd0,  16'h7FFF, 1'b0, 16'h0000},
        '{1'b1, 5'd2,  16'h0001, 1'b1, 16'h0001},
        '{1'b0, 5'd0,  16'h0000, 1'b1, 16'h0000},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, 16'h7FFF},
        '{1'b1, 5'd2,  16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b0, 5'd0,  16'h0001, 1'b1, 16'h8000},
        '{1'b1, 5'd15, 16'hABCD, 1'b1, 16'hABCD},
        '{1'b0, 5'd0,  16'h0000, 1'b0, 16'h0000},
        '{1'b1, 5'd3,  16'h0007, 1'b1, 16'h0007},
        '{1'b0, 5'd0,  16'h0000, 1'b0, 16'h0000}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pma_sample_if  sample_bus ();
    pma_average_if average_bus ();

    prefilled_moving_average DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_ch  (sample_bus),
        .average_ch (average_bus)
    );

    // Window model
    logic [DATA_W-1:0] ring [MAX_WIN];
    logic [19:0]       ring_sum;
    logic [3:0]        oldest;
    logic              primed_q;
    logic [4:0]        len_reg;

    logic [DATA_W-1:0] pending_averages [$];
    int                mismatches    = 0;
    int                samples_sent  = 0;
    int                results_seen  = 0;
    int                cycle_count   = 0;
    bit                hold_request  = 1'b0;
    bit                hold_done     = 1'b0;

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] next_average(input logic [DATA_W-1:0] s);
        int unsigned n;
        n = (len_reg == 0) ? 1 : ((len_reg > MAX_WIN) ? MAX_WIN : len_reg);
        if (!primed_q)
        begin
            for (int i = 0; i < n; i++)
                ring[i] = s;
            ring_sum = 20'(n * s);
            oldest   = '0;
            primed_q = 1'b1;
        end
        if (oldest >= n)
            oldest = '0;
        ring_sum     = ring_sum - ring[oldest] + s;
        ring[oldest] = s;
        oldest       = (oldest + 1 >= n) ? 4'd0 : 4'(oldest + 1);
        return DATA_W'(ring_sum / n);
    endfunction

    function automatic int draw_gap(input int count);
        // Leave stretches with no idling at all.
        if ((count % 100) >= 80)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] s, input bit typed,
                               input logic [DATA_W-1:0] typed_avg);
        int                gap;
        logic [DATA_W-1:0] model_avg;
        gap = draw_gap(samples_sent);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        do @(posedge clk); while (!sample_bus.ready);
        model_avg = next_average(s);
        pending_averages.push_back(typed ? typed_avg : model_avg);
        samples_sent++;
    endtask

    // Drop valid and hold until every average is back and the block is quiet.
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        while (pending_averages.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [4:0] len);
        logic [APB_DATA_W-1:0] word;
        word      = $urandom();
        word[4:0] = len;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_LENGTH;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        len_reg  = len;
        primed_q = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [4:0] draw_length();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'($urandom_range(17, 31));
            2:       return 5'd16;
            3:       return 5'd1;
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    // Average side: random stalls, one long hold-off, compare every transfer.
    initial
    begin
        int                gap;
        logic [DATA_W-1:0] want;
        average_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            else
            begin
                gap = ((results_seen % 90) >= 70) ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0)
            begin
                average_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            average_bus.ready <= 1'b1;
            do @(posedge clk); while (!average_bus.valid);
            results_seen++;
            if (pending_averages.size() == 0)
            begin
                $display("%0t: unexpected average, expected none, actual %h",
                         $time, average_bus.average);
                mismatches++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (average_bus.average !== want)
                begin
                    $display("%0t: average mismatch, expected %h, actual %h",
                             $time, want, average_bus.average);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int            phase;
        int            phase_items;
        int            random_sent;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        len_reg  = 5'(LEN_RESET);
        ring_sum = '0;
        oldest   = '0;
        primed_q = 1'b0;
        for (int i = 0; i < MAX_WIN; i++)
            ring[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].set_len)
            begin
                wait_idle();
                write_window_length(directed_steps[i].len);
            end
            send_sample(directed_steps[i].sample, directed_steps[i].typed,
                        directed_steps[i].average);
        end

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            write_window_length(draw_length());
            if (phase == 5)
                hold_request = 1'b1;
            phase_items = $urandom_range(10, 50);
            for (int k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                send_sample(draw_sample(), 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_averages.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
